/* hdl/fcbm_pkg.sv */
`default_nettype none

package fcbm_pkg;

    localparam int FREEZE_WRITES = 3;   // writes after the button release that force ultimax
    localparam int OFFSET_BITS   = 14;  // bank offset width, 13 or 14
    localparam int WRITE_BITS    = 13;  // RAM write offset width
    localparam int MEM_ADDR_W    = 17;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 32;

    localparam logic [2:0] FREEZE_DONE = 3'(FREEZE_WRITES + 1);

    localparam logic [1:0] MEM_NONE = 2'd0;
    localparam logic [1:0] MEM_ROM  = 2'd1;
    localparam logic [1:0] MEM_RAM  = 2'd2;

    // IO1 control byte bits
    localparam int CTL_GAME  = 0;
    localparam int CTL_EXROM = 1;
    localparam int CTL_BANK0 = 2;
    localparam int CTL_KILL  = 3;
    localparam int CTL_BANK1 = 4;
    localparam int CTL_BANK2 = 5;

    typedef struct packed {
        logic        action;
        logic        io1_n;
        logic        roml_n;
        logic        romh_n;
        logic        freeze_button;
        logic [15:0] bus_addr;
        logic [7:0]  bus_data;
    } item_t;

    typedef struct packed {
        logic                  drive_bus;
        logic [1:0]            mem_kind;
        logic [MEM_ADDR_W-1:0] mem_addr;
        logic                  mem_write;
        logic [7:0]            mem_wdata;
        logic                  exrom_low;
        logic                  game_low;
        logic                  led_on;
        logic                  nmi_low;
    } result_t;

    typedef struct packed {
        logic [2:0] rom_bank;
        logic       ram_mapped;
        logic       cart_enabled;
        logic       exrom_level;
        logic       game_level;
        logic       led_level;
        logic       nmi_level;
        logic       button_held;
        logic [2:0] freeze_count;
    } mapper_state_t;

    localparam mapper_state_t STATE_RESET = '{
        rom_bank:     3'd0,
        ram_mapped:   1'b1,
        cart_enabled: 1'b1,
        exrom_level:  1'b0,
        game_level:   1'b1,
        led_level:    1'b1,
        nmi_level:    1'b0,
        button_held:  1'b0,
        freeze_count: 3'd0
    };

    function automatic logic [MEM_ADDR_W-1:0] bank_addr(
        input logic [2:0]             bank,
        input logic [OFFSET_BITS-1:0] offset
    );
        return MEM_ADDR_W'({bank, offset});
    endfunction

endpackage

`default_nettype wire

/* hdl/fcbm_step.sv */
`default_nettype none

module fcbm_step (
    input  wire fcbm_pkg::item_t         item_i,
    input  wire fcbm_pkg::mapper_state_t state_i,
    output fcbm_pkg::mapper_state_t      state_o,
    output fcbm_pkg::result_t            result_o
);

    fcbm_pkg::mapper_state_t st;
    fcbm_pkg::result_t       res;
    logic                    any_sel;
    logic [7:0]              d;

    always_comb begin
        st      = state_i;
        res     = '0;
        d       = item_i.bus_data;
        any_sel = !item_i.io1_n || !item_i.roml_n || !item_i.romh_n;

        if (!item_i.action) begin
            if (any_sel && st.cart_enabled) begin
                res.drive_bus = 1'b1;
                res.mem_kind  = (!item_i.roml_n && st.ram_mapped) ? fcbm_pkg::MEM_RAM
                                                                  : fcbm_pkg::MEM_ROM;
                res.mem_addr  = fcbm_pkg::bank_addr(st.rom_bank,
                                    item_i.bus_addr[fcbm_pkg::OFFSET_BITS-1:0]);
            end else if (item_i.freeze_button) begin
                st.button_held = 1'b1;
            end else if (st.button_held) begin
                // button released: pull NMI and start counting writes
                st.nmi_level    = 1'b1;
                st.button_held  = 1'b0;
                st.freeze_count = 3'd1;
            end
        end else begin
            // freeze counter goes first; the remap is seen by this same write
            if (st.freeze_count != 3'd0) begin
                st.freeze_count = st.freeze_count + 3'd1;
                if (st.freeze_count == fcbm_pkg::FREEZE_DONE) begin
                    st.rom_bank     = 3'd0;
                    st.ram_mapped   = 1'b1;
                    st.cart_enabled = 1'b1;
                    st.exrom_level  = 1'b0;
                    st.game_level   = 1'b1;
                    st.led_level    = 1'b1;
                    st.freeze_count = 3'd0;
                end
            end
            if (st.cart_enabled) begin
                if (!item_i.io1_n) begin
                    st.rom_bank    = {d[fcbm_pkg::CTL_BANK2], d[fcbm_pkg::CTL_BANK1],
                                      d[fcbm_pkg::CTL_BANK0]};
                    st.exrom_level = d[fcbm_pkg::CTL_EXROM];
                    st.game_level  = !d[fcbm_pkg::CTL_GAME];
                    st.led_level   = !d[fcbm_pkg::CTL_KILL];
                    if (d[fcbm_pkg::CTL_KILL]) begin
                        st.cart_enabled = 1'b0;
                    end else begin
                        st.ram_mapped = !d[fcbm_pkg::CTL_EXROM];
                    end
                    if (d[fcbm_pkg::CTL_GAME]) begin
                        st.nmi_level = 1'b0;
                    end
                end else if (!item_i.roml_n && st.ram_mapped) begin
                    res.mem_kind  = fcbm_pkg::MEM_RAM;
                    res.mem_addr  = fcbm_pkg::bank_addr(st.rom_bank,
                                        fcbm_pkg::OFFSET_BITS'(
                                            item_i.bus_addr[fcbm_pkg::WRITE_BITS-1:0]));
                    res.mem_write = 1'b1;
                    res.mem_wdata = d;
                end
            end
        end

        res.exrom_low = st.exrom_level;
        res.game_low  = st.game_level;
        res.led_on    = st.led_level;
        res.nmi_low   = st.nmi_level;
    end

    assign state_o  = st;
    assign result_o = res;

endmodule

`default_nettype wire

/* hdl/freezer_cartridge_bank_mapper_unit.sv */
// channel | dir | tdata (low bit up)                          | tuser
// s_axis  | in  | io1_n, roml_n, romh_n, freeze_button,       | action
//         |     | bus_addr[15:0], bus_data[7:0], pad          |
// m_axis  | out | drive_bus, mem_addr[16:0], mem_write,       | mem_kind[1:0]
//         |     | mem_wdata[7:0], exrom_low, game_low,        |
//         |     | led_on, nmi_low, pad                        |
//
// One word per clock sustained while m_axis_tready stays high. A word is held in the input
// register, then the mapper logic updates the state register and loads the result register,
// which drives m_axis_tvalid.
// aresetn (synchronous) returns the mapper to ultimax with RAM bank 0 mapped.
// A stalled result register holds; the input register still takes a word,
// and s_axis_tready drops only when both registers are full.
`default_nettype none

module freezer_cartridge_bank_mapper_unit (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    // [0] io1_n [1] roml_n [2] romh_n [3] freeze_button [19:4] bus_addr
    // [27:20] bus_data [31:28] zero
    input  wire [fcbm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] action
    input  wire        s_axis_tuser,
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    // [0] drive_bus [17:1] mem_addr [18] mem_write [26:19] mem_wdata
    // [27] exrom_low [28] game_low [29] led_on [30] nmi_low [31] zero
    output logic [fcbm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [1:0] mem_kind
    output logic [1:0]  m_axis_tuser
);

    fcbm_pkg::item_t         in_item_reg;
    logic                    in_valid_reg;
    fcbm_pkg::mapper_state_t state_reg;
    fcbm_pkg::mapper_state_t state_next;
    fcbm_pkg::result_t       result_next;
    fcbm_pkg::result_t       out_reg;
    logic                    out_valid_reg;
    logic                    advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_item_reg.action        <= s_axis_tuser;
            in_item_reg.io1_n         <= s_axis_tdata[0];
            in_item_reg.roml_n        <= s_axis_tdata[1];
            in_item_reg.romh_n        <= s_axis_tdata[2];
            in_item_reg.freeze_button <= s_axis_tdata[3];
            in_item_reg.bus_addr      <= s_axis_tdata[19:4];
            in_item_reg.bus_data      <= s_axis_tdata[27:20];
        end
    end

    fcbm_step u_step (
        .item_i   (in_item_reg),
        .state_i  (state_reg),
        .state_o  (state_next),
        .result_o (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fcbm_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.mem_kind;
    assign m_axis_tdata  = {1'b0, out_reg.nmi_low, out_reg.led_on, out_reg.game_low,
                            out_reg.exrom_low, out_reg.mem_wdata, out_reg.mem_write,
                            out_reg.mem_addr, out_reg.drive_bus};

endmodule

`default_nettype wire

/* hdl/fcbm_checker.sv */
`default_nettype none

module fcbm_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [fcbm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire [1:0]  m_axis_tuser
);

    // nothing comes out right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    // a RAM write is always a RAM access and never a driven read
    a_write_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[18] |->
            m_axis_tuser == fcbm_pkg::MEM_RAM && !m_axis_tdata[0])
        else $error("RAM write with wrong kind or bus drive");

    // driven read always has a memory access, no write data
    a_drive_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[0] |->
            (m_axis_tuser == fcbm_pkg::MEM_ROM || m_axis_tuser == fcbm_pkg::MEM_RAM)
            && m_axis_tdata[26:18] == 9'd0)
        else $error("driven read without memory access");

    // no access means a clean address
    a_idle_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == fcbm_pkg::MEM_NONE |->
            m_axis_tdata[26:0] == 27'd0)
        else $error("idle access carries address or data");

endmodule

bind freezer_cartridge_bank_mapper_unit fcbm_checker u_fcbm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam logic CYC_READ  = 1'b0;
    localparam logic CYC_WRITE = 1'b1;

    // select lines as {romh_n, roml_n, io1_n}
    localparam logic [2:0] SEL_NONE = 3'b111;
    localparam logic [2:0] SEL_IO1  = 3'b110;
    localparam logic [2:0] SEL_ROML = 3'b101;
    localparam logic [2:0] SEL_ROMH = 3'b011;
    localparam logic [2:0] SEL_ALL  = 3'b000;

    localparam logic [15:0] READ_MASK  = 16'((1 << fcbm_pkg::OFFSET_BITS) - 1);
    localparam logic [15:0] WRITE_MASK = 16'((1 << fcbm_pkg::WRITE_BITS) - 1);

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 220;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    fcbm_pkg::mapper_state_t mapper;
    fcbm_pkg::result_t       pending_bus_results[$];
    int            error_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_left = 0;
    int            idle_cycles = 0;
    logic          button_level = 1'b0;

    freezer_cartridge_bank_mapper_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 aclk = ~aclk;

    function automatic void go_ultimax();
        mapper.rom_bank     = 3'd0;
        mapper.ram_mapped   = 1'b1;
        mapper.cart_enabled = 1'b1;
        mapper.exrom_level  = 1'b0;
        mapper.game_level   = 1'b1;
        mapper.led_level    = 1'b1;
    endfunction

    // advances the mapper state by one bus cycle and returns the word it yields
    function automatic fcbm_pkg::result_t map_bus_cycle(input fcbm_pkg::item_t it);
        fcbm_pkg::result_t r;
        logic              io1, roml, romh;
        logic [7:0]        d;
        r    = '0;
        io1  = !it.io1_n;
        roml = !it.roml_n;
        romh = !it.romh_n;
        d    = it.bus_data;
        if (it.action == CYC_READ) begin
            if ((io1 || roml || romh) && mapper.cart_enabled) begin
                r.drive_bus = 1'b1;
                r.mem_kind  = (roml && mapper.ram_mapped) ? fcbm_pkg::MEM_RAM
                                                          : fcbm_pkg::MEM_ROM;
                r.mem_addr  = fcbm_pkg::MEM_ADDR_W'(
                                  (17'(mapper.rom_bank) << fcbm_pkg::OFFSET_BITS)
                                  | 17'(it.bus_addr & READ_MASK));
            end else if (it.freeze_button) begin
                mapper.button_held = 1'b1;
            end else if (mapper.button_held) begin
                mapper.nmi_level    = 1'b1;
                mapper.button_held  = 1'b0;
                mapper.freeze_count = 3'd1;
            end
        end else begin
            // freeze counter runs before the write is decoded
            if (mapper.freeze_count != 3'd0) begin
                mapper.freeze_count = mapper.freeze_count + 3'd1;
                if (mapper.freeze_count == fcbm_pkg::FREEZE_DONE) begin
                    go_ultimax();
                    mapper.freeze_count = 3'd0;
                end
            end
            if (mapper.cart_enabled) begin
                if (io1) begin
                    mapper.rom_bank    = {d[fcbm_pkg::CTL_BANK2], d[fcbm_pkg::CTL_BANK1],
                                          d[fcbm_pkg::CTL_BANK0]};
                    mapper.exrom_level = d[fcbm_pkg::CTL_EXROM];
                    mapper.game_level  = !d[fcbm_pkg::CTL_GAME];
                    mapper.led_level   = !d[fcbm_pkg::CTL_KILL];
                    if (d[fcbm_pkg::CTL_KILL])
                        mapper.cart_enabled = 1'b0;
                    else
                        mapper.ram_mapped = !d[fcbm_pkg::CTL_EXROM];
                    if (d[fcbm_pkg::CTL_GAME])
                        mapper.nmi_level = 1'b0;
                end else if (roml && mapper.ram_mapped) begin
                    r.mem_kind  = fcbm_pkg::MEM_RAM;
                    r.mem_addr  = fcbm_pkg::MEM_ADDR_W'(
                                      (17'(mapper.rom_bank) << fcbm_pkg::OFFSET_BITS)
                                      | 17'(it.bus_addr & WRITE_MASK));
                    r.mem_write = 1'b1;
                    r.mem_wdata = d;
                end
            end
        end
        r.exrom_low = mapper.exrom_level;
        r.game_low  = mapper.game_level;
        r.led_on    = mapper.led_level;
        r.nmi_low   = mapper.nmi_level;
        return r;
    endfunction

    function automatic fcbm_pkg::item_t bus_cycle(input logic action, input logic [2:0] sel,
                                                  input logic button,
                                                  input logic [15:0] addr,
                                                  input logic [7:0] data);
        fcbm_pkg::item_t it;
        it.action        = action;
        it.io1_n         = sel[0];
        it.roml_n        = sel[1];
        it.romh_n        = sel[2];
        it.freeze_button = button;
        it.bus_addr      = addr;
        it.bus_data      = data;
        return it;
    endfunction

    // mostly single selects and button press/release runs; kill is kept rare
    function automatic fcbm_pkg::item_t random_bus_cycle();
        fcbm_pkg::item_t it;
        logic [2:0]      sel;
        int              pick;
        pick = $urandom_range(15);
        if (pick < 4)       sel = SEL_IO1;
        else if (pick < 8)  sel = SEL_ROML;
        else if (pick < 11) sel = SEL_ROMH;
        else if (pick < 15) sel = SEL_NONE;
        else                sel = 3'($urandom_range(7));
        if ($urandom_range(3) == 0)
            button_level = !button_level;
        it = bus_cycle(1'($urandom_range(1)), sel, button_level,
                       16'($urandom_range(16'hffff)), 8'($urandom_range(255)));
        if (it.action == CYC_WRITE && !it.io1_n && it.bus_data[fcbm_pkg::CTL_KILL]
            && $urandom_range(3) != 0)
            it.bus_data[fcbm_pkg::CTL_KILL] = 1'b0;
        return it;
    endfunction

    task automatic issue_bus_cycle(input fcbm_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, it.bus_data, it.bus_addr, it.freeze_button,
                          it.romh_n, it.roml_n, it.io1_n};
        s_axis_tuser  <= it.action;
        do @(posedge aclk); while (!s_axis_tready);
        pending_bus_results.push_back(map_bus_cycle(it));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_bus_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 40)
            $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        fcbm_pkg::result_t got;
        fcbm_pkg::result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.drive_bus = m_axis_tdata[0];
            got.mem_addr  = m_axis_tdata[17:1];
            got.mem_write = m_axis_tdata[18];
            got.mem_wdata = m_axis_tdata[26:19];
            got.exrom_low = m_axis_tdata[27];
            got.game_low  = m_axis_tdata[28];
            got.led_on    = m_axis_tdata[29];
            got.nmi_low   = m_axis_tdata[30];
            got.mem_kind  = m_axis_tuser;
            if (pending_bus_results.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata, 32'd0);
            end else begin
                want = pending_bus_results.pop_front();
                if (got.drive_bus != want.drive_bus)
                    report_mismatch("drive_bus", 32'(got.drive_bus), 32'(want.drive_bus));
                if (got.mem_kind != want.mem_kind)
                    report_mismatch("mem_kind", 32'(got.mem_kind), 32'(want.mem_kind));
                if (got.mem_addr != want.mem_addr)
                    report_mismatch("mem_addr", 32'(got.mem_addr), 32'(want.mem_addr));
                if (got.mem_write != want.mem_write)
                    report_mismatch("mem_write", 32'(got.mem_write), 32'(want.mem_write));
                if (got.mem_wdata != want.mem_wdata)
                    report_mismatch("mem_wdata", 32'(got.mem_wdata), 32'(want.mem_wdata));
                if (got.exrom_low != want.exrom_low)
                    report_mismatch("exrom_low", 32'(got.exrom_low), 32'(want.exrom_low));
                if (got.game_low != want.game_low)
                    report_mismatch("game_low", 32'(got.game_low), 32'(want.game_low));
                if (got.led_on != want.led_on)
                    report_mismatch("led_on", 32'(got.led_on), 32'(want.led_on));
                if (got.nmi_low != want.nmi_low)
                    report_mismatch("nmi_low", 32'(got.nmi_low), 32'(want.nmi_low));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved in %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // after reset: ultimax, RAM at ROML, bank 0
    task automatic test_read_mapping();
        issue_bus_cycle(bus_cycle(CYC_READ, SEL_ROML, 1'b0, 16'hffff, 8'h00));
        // driven read with the button down: button not sampled
        issue_bus_cycle(bus_cycle(CYC_READ, SEL_ROMH, 1'b1, 16'h0000, 8'hff));
        issue_bus_cycle(bus_cycle(CYC_READ, SEL_IO1, 1'b0, 16'hde00, 8'h5a));
        issue_bus_cycle(bus_cycle(CYC_READ, SEL_NONE, 1'b0, 16'h8000, 8'h00));
    endtask

    task automatic test_control_writes();
        // bank 7, EXROM low, NMI release, ROM at ROML
        issue_bus_cycle(bus_cycle(CYC_WRITE, SEL_IO1, 1'b0, 16'hde00, 8'h37));
        issue_bus_cycle(bus_cycle(CYC_READ, SEL_ROML, 1'b0, 16'h1234, 8'h00));
        issue_bus_cycle(bus_cycle(CYC_WRITE, SEL_ROML, 1'b0, 16'h8000, 8'ha5));
        // top bits ignored, bank 1, RAM back at ROML
        issue_bus_cycle(bus_cycle(CYC_WRITE, SEL_IO1, 1'b0, 16'hde7f, 8'hc4));
        issue_bus_cycle(bus_cycle(CYC_READ, SEL_ALL, 1'b0, 16'hffff, 8'h00));
    endtask

    task automatic test_ram_writes();
        issue_bus_cycle(bus_cycle(CYC_WRITE, SEL_ROML, 1'b0, 16'hffff, 8'hff));
        issue_bus_cycle(bus_cycle(CYC_WRITE, SEL_ROML, 1'b1, 16'h0000, 8'h00));
    endtask

    // release arms NMI; the third write forces ultimax before it is decoded
    task automatic test_freeze();
        issue_bus_cycle(bus_cycle(CYC_READ, SEL_NONE, 1'b1, 16'h0000, 8'h00));
        issue_bus_cycle(bus_cycle(CYC_READ, SEL_NONE, 1'b0, 16'h0000, 8'h00));
        issue_bus_cycle(bus_cycle(CYC_WRITE, SEL_NONE, 1'b0, 16'h0100, 8'h11));
        issue_bus_cycle(bus_cycle(CYC_WRITE, SEL_IO1, 1'b0, 16'hde00, 8'h08));
        issue_bus_cycle(bus_cycle(CYC_WRITE, SEL_ROML, 1'b0, 16'h9fff, 8'h3c));
    endtask

    // killed cart ignores IO1 and ROML; a freeze with a restarted count revives it
    task automatic test_kill_and_revive();
        issue_bus_cycle(bus_cycle(CYC_WRITE, SEL_IO1, 1'b0, 16'hde00, 8'h28));
        issue_bus_cycle(bus_cycle(CYC_READ, SEL_ROML, 1'b0, 16'h8000, 8'h00));
        issue_bus_cycle(bus_cycle(CYC_WRITE, SEL_IO1, 1'b0, 16'hde00, 8'h00));
        issue_bus_cycle(bus_cycle(CYC_WRITE, SEL_ROML, 1'b0, 16'h8001, 8'h77));
        issue_bus_cycle(bus_cycle(CYC_READ, SEL_ROMH, 1'b1, 16'he000, 8'h00));
        issue_bus_cycle(bus_cycle(CYC_READ, SEL_NONE, 1'b0, 16'h0000, 8'h00));
        issue_bus_cycle(bus_cycle(CYC_READ, SEL_NONE, 1'b1, 16'h0000, 8'h00));
        issue_bus_cycle(bus_cycle(CYC_WRITE, SEL_NONE, 1'b0, 16'h0000, 8'h00));
        issue_bus_cycle(bus_cycle(CYC_READ, SEL_NONE, 1'b0, 16'h0000, 8'h00));
        repeat (fcbm_pkg::FREEZE_WRITES)
            issue_bus_cycle(bus_cycle(CYC_WRITE, SEL_NONE, 1'b0, 16'h0000, 8'h00));
        issue_bus_cycle(bus_cycle(CYC_READ, SEL_ROML, 1'b0, 16'h8000, 8'h00));
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (PHASE_ITEMS)
            issue_bus_cycle(random_bus_cycle());
        drain_results();
    endtask

    // receiver holds off long enough for the pipe to fill and stall the input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        repeat (60)
            issue_bus_cycle(random_bus_cycle());
        drain_results();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        mapper        = fcbm_pkg::STATE_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_read_mapping();
        test_control_writes();
        test_ram_writes();
        test_freeze();
        test_kill_and_revive();
        drain_results();

        test_random_traffic(0, 0);
        test_random_traffic(64, 0);
        test_random_traffic(0, 64);
        test_random_traffic(16, 16);
        test_backpressure();

        repeat (8) @(posedge aclk);
        if (error_count == 0 && pending_bus_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
